// ===== design/pmgp_pkg.sv =====
// Shared types and constants for the particle mesh gather and push block.
package pmgp_pkg;

  // Mesh size limits.
  localparam int MAX_CELLS_X = 64;
  localparam int MAX_CELLS_Y = 64;
  localparam int QW = ($clog2(MAX_CELLS_X) > $clog2(MAX_CELLS_Y)) ?
                      $clog2(MAX_CELLS_X) : $clog2(MAX_CELLS_Y);
  localparam int MESH_DEPTH = (MAX_CELLS_X + 1) * (MAX_CELLS_Y + 1);
  localparam int MESH_AW = $clog2(MESH_DEPTH);
  localparam int DIV_LAT = QW + 1;

  // Field widths.
  localparam int POS_W = 17;
  localparam int FLD_W = 24;
  localparam int NIDX_W = 13;
  localparam int CN_W = 7;
  localparam int POS_ONE = 65536;

  // Configuration register indexes and reset values.
  localparam logic [1:0] REG_CELL_WIDTH_X = 2'd0;
  localparam logic [1:0] REG_CELL_WIDTH_Y = 2'd1;
  localparam logic [1:0] REG_CELLS_X = 2'd2;
  localparam logic [1:0] REG_CELLS_Y = 2'd3;
  localparam logic [POS_W-1:0] CELL_WIDTH_RST = POS_W'(1024);
  localparam logic [CN_W-1:0] CELLS_RST = CN_W'(64);

  // Item functions.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_MOVE = 1'b1;

  typedef struct packed {
    logic func;
    logic [NIDX_W-1:0] node_index;
    logic signed [FLD_W-1:0] node_field;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic is_active;
    logic batch_end;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] new_x;
    logic [POS_W-1:0] new_y;
    logic still_active;
    logic batch_done;
  } out_item_t;

endpackage

// ===== design/pmgp_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module pmgp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== design/pmgp_div.sv =====
// Pipelined restoring divider that finds a saturating cell index, one bit a stage.
module pmgp_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [pmgp_pkg::POS_W-1:0] num,
  input  logic [pmgp_pkg::POS_W-1:0] den,
  output logic                       sat,
  output logic [pmgp_pkg::QW-1:0]    quo
);
  import pmgp_pkg::*;

  localparam int DW = POS_W + QW;

  logic [DW-1:0] rem [0:QW];
  logic [DW-1:0] dv  [0:QW];
  logic [QW-1:0] qv  [0:QW];
  logic          st  [0:QW];

  // First stage flags a quotient at or beyond the index range.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= DW'(num);
      dv[0]  <= DW'(den);
      qv[0]  <= '0;
      st[0]  <= (DW'(num) >= (DW'(den) << QW));
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 1; k <= QW; k++) begin : g_bit
    localparam int B = QW - k;
    logic [DW-1:0] sh;
    logic          ge;
    assign sh = dv[k-1] << B;
    assign ge = (rem[k-1] >= sh);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? (rem[k-1] - sh) : rem[k-1];
        qv[k]  <= ge ? (qv[k-1] | (QW'(1) << B)) : qv[k-1];
        dv[k]  <= dv[k-1];
        st[k]  <= st[k-1];
      end
    end
  end

  assign sat = st[QW];
  assign quo = qv[QW];

endmodule

// ===== design/particle_mesh_gather_push_top.sv =====
// Top level of the particle mesh gather and push block.
// The block accepts one item per cycle while no result waits, and out_valid for a move result
// rises once its input beat has passed the divider payload line, stages 1 to 10 and the output
// register. A stalled output stalls the whole pipeline in place. The latency is set by the
// one-bit-a-stage cell index divider and the split multiplier chain of the bilinear gather.
// Mesh writes take effect in item order and produce no result. The mesh is held in two copies
// of a dual-read RAM so all four corner nodes are read in the same cycle. It is not cleared at
// reset, and a node must be written before a particle reads it.
module particle_mesh_gather_push_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pmgp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pmgp_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import pmgp_pkg::*;

  localparam int NXW = QW + 1;
  localparam int CPW = QW + POS_W;
  localparam int RW = 2 * QW + 1;

  // Configuration registers.
  logic [POS_W-1:0] cell_width_x, cell_width_y;
  logic [CN_W-1:0]  cells_x, cells_y;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width_x <= CELL_WIDTH_RST;
      cell_width_y <= CELL_WIDTH_RST;
      cells_x      <= CELLS_RST;
      cells_y      <= CELLS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CELL_WIDTH_X: cell_width_x <= pwdata[POS_W-1:0];
        REG_CELL_WIDTH_Y: cell_width_y <= pwdata[POS_W-1:0];
        REG_CELLS_X:      cells_x      <= pwdata[CN_W-1:0];
        REG_CELLS_Y:      cells_y      <= pwdata[CN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[3:2])
      REG_CELL_WIDTH_X: prdata = 32'(cell_width_x);
      REG_CELL_WIDTH_Y: prdata = 32'(cell_width_y);
      REG_CELLS_X:      prdata = 32'(cells_x);
      REG_CELLS_Y:      prdata = 32'(cells_y);
      default:          prdata = '0;
    endcase
  end

  // Effective cell counts, the last cell index and the node row pitch.
  logic [NXW-1:0] nx, ny, gx;
  logic [QW-1:0]  nxm1, nym1;

  always_comb begin
    if (cells_x == '0) begin
      nx = NXW'(1);
    end else if (32'(cells_x) > 32'(MAX_CELLS_X)) begin
      nx = NXW'(MAX_CELLS_X);
    end else begin
      nx = NXW'(cells_x);
    end
    if (cells_y == '0) begin
      ny = NXW'(1);
    end else if (32'(cells_y) > 32'(MAX_CELLS_Y)) begin
      ny = NXW'(MAX_CELLS_Y);
    end else begin
      ny = NXW'(cells_y);
    end
    nxm1 = QW'(nx - NXW'(1));
    nym1 = QW'(ny - NXW'(1));
    gx   = nx + NXW'(1);
  end

  // Global pipeline advance: everything moves unless a result waits.
  logic en;
  assign en = ~out_valid | out_ready;
  assign in_ready = en;

  // Payload line that runs beside the dividers.
  logic     vl [0:DIV_LAT-1];
  in_item_t dl [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        vl[i] <= 1'b0;
      end
    end else if (en) begin
      vl[0] <= in_valid;
      for (int i = 1; i < DIV_LAT; i++) begin
        vl[i] <= vl[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= in_data;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  // Cell index dividers for both axes.
  logic          sat_x, sat_y;
  logic [QW-1:0] quo_x, quo_y;

  pmgp_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (in_data.pos_x),
    .den (cell_width_x),
    .sat (sat_x),
    .quo (quo_x)
  );

  pmgp_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (in_data.pos_y),
    .den (cell_width_y),
    .sat (sat_y),
    .quo (quo_y)
  );

  // Payload of the stages after the dividers.
  in_item_t d1, d2, d3, d4, d5, d6, d7, d8, d9, d10;

  // Valid bits of the stages after the dividers.
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1  <= vl[DIV_LAT-1];
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      v5  <= v4;
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
      out_valid <= v10 & (d10.func == FUNC_MOVE);
    end
  end

  // Stage 1: clamp the cell indexes into the grid.
  logic [QW-1:0] ci1, cj1;

  always_ff @(posedge clk) begin
    if (en) begin
      d1  <= dl[DIV_LAT-1];
      ci1 <= (sat_x || (quo_x > nxm1)) ? nxm1 : quo_x;
      cj1 <= (sat_y || (quo_y > nym1)) ? nym1 : quo_y;
    end
  end

  // Stage 2: cell origins and the node row base.
  logic [CPW-1:0] cidx2, cjdy2;
  logic [RW-1:0]  row2;
  logic [QW-1:0]  ci2;

  always_ff @(posedge clk) begin
    if (en) begin
      d2    <= d1;
      cidx2 <= CPW'(ci1) * CPW'(cell_width_x);
      cjdy2 <= CPW'(cj1) * CPW'(cell_width_y);
      row2  <= RW'(cj1) * RW'(gx);
      ci2   <= ci1;
    end
  end

  // Stage 3: offsets inside the cell and the base node address.
  logic [CPW-1:0]     diff_x, diff_y;
  logic [POS_W-1:0]   lx3, ly3;
  logic [MESH_AW-1:0] base3;

  assign diff_x = CPW'(d2.pos_x) - cidx2;
  assign diff_y = CPW'(d2.pos_y) - cjdy2;

  always_ff @(posedge clk) begin
    if (en) begin
      d3    <= d2;
      lx3   <= diff_x[POS_W-1:0];
      ly3   <= diff_y[POS_W-1:0];
      base3 <= MESH_AW'(32'(row2) + 32'(ci2));
    end
  end

  // Stage 4: mesh access and the far-corner weights; writes land here in item order.
  logic [MESH_AW-1:0] a0, a1, a2, a3;
  logic               mesh_we;
  logic [FLD_W-1:0]   rd0, rd1, rd2, rd3;
  logic signed [17:0] wx4, wy4, lx4, ly4;

  assign a0 = base3;
  assign a1 = base3 + MESH_AW'(1);
  assign a2 = base3 + MESH_AW'(gx);
  assign a3 = a2 + MESH_AW'(1);
  assign mesh_we = en & v3 & (d3.func == FUNC_WRITE) &
                   (32'(d3.node_index) < 32'(MESH_DEPTH));

  pmgp_ram #(.WIDTH(FLD_W), .DEPTH(MESH_DEPTH)) u_mesh_lo (
    .clk     (clk),
    .we      (mesh_we),
    .waddr   (MESH_AW'(d3.node_index)),
    .wdata   (d3.node_field),
    .re      (en),
    .raddr_a (a0),
    .raddr_b (a1),
    .rdata_a (rd0),
    .rdata_b (rd1)
  );

  pmgp_ram #(.WIDTH(FLD_W), .DEPTH(MESH_DEPTH)) u_mesh_hi (
    .clk     (clk),
    .we      (mesh_we),
    .waddr   (MESH_AW'(d3.node_index)),
    .wdata   (d3.node_field),
    .re      (en),
    .raddr_a (a2),
    .raddr_b (a3),
    .rdata_a (rd2),
    .rdata_b (rd3)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      d4  <= d3;
      wx4 <= $signed({1'b0, cell_width_x}) - $signed({1'b0, lx3});
      wy4 <= $signed({1'b0, cell_width_y}) - $signed({1'b0, ly3});
      lx4 <= $signed({1'b0, lx3});
      ly4 <= $signed({1'b0, ly3});
    end
  end

  // Stage 5: y weight times node value for each corner.
  logic signed [FLD_W-1:0] nd [0:3];
  logic signed [17:0]      wyk [0:3];
  logic signed [17:0]      wxk [0:3];
  logic signed [41:0]      p5 [0:3];
  logic signed [17:0]      wf5 [0:3];

  always_comb begin
    nd[0] = $signed(rd0);
    nd[1] = $signed(rd1);
    nd[2] = $signed(rd2);
    nd[3] = $signed(rd3);
    wyk[0] = wy4;
    wyk[1] = wy4;
    wyk[2] = ly4;
    wyk[3] = ly4;
    wxk[0] = wx4;
    wxk[1] = lx4;
    wxk[2] = wx4;
    wxk[3] = lx4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d5 <= d4;
      for (int k = 0; k < 4; k++) begin
        p5[k]  <= wyk[k] * nd[k];
        wf5[k] <= wxk[k];
      end
    end
  end

  // Stage 6: x weight times the partial product, split into high and low halves.
  logic signed [38:0] mh6 [0:3];
  logic signed [39:0] ml6 [0:3];

  always_ff @(posedge clk) begin
    if (en) begin
      d6 <= d5;
      for (int k = 0; k < 4; k++) begin
        mh6[k] <= wf5[k] * $signed(p5[k][41:21]);
        ml6[k] <= wf5[k] * $signed({1'b0, p5[k][20:0]});
      end
    end
  end

  // Stage 7: recombine the halves into each corner term.
  logic signed [61:0] t7 [0:3];

  always_ff @(posedge clk) begin
    if (en) begin
      d7 <= d6;
      for (int k = 0; k < 4; k++) begin
        t7[k] <= (62'(mh6[k]) <<< 21) + 62'(ml6[k]);
      end
    end
  end

  // Stage 8 and 9: sum the four corner terms.
  logic signed [61:0] s8a, s8b, acc9;

  always_ff @(posedge clk) begin
    if (en) begin
      d8   <= d7;
      s8a  <= t7[0] + t7[1];
      s8b  <= t7[2] + t7[3];
      d9   <= d8;
      acc9 <= s8a + s8b;
    end
  end

  // Stage 10: gathered field (floor by 2^32) times cell width.
  logic signed [29:0] fi9;
  logic signed [47:0] px10, py10;

  assign fi9 = acc9[61:32];

  always_ff @(posedge clk) begin
    if (en) begin
      d10  <= d9;
      px10 <= fi9 * $signed({1'b0, cell_width_x});
      py10 <= fi9 * $signed({1'b0, cell_width_y});
    end
  end

  // Output stage: push the position and check that it stays in the unit square.
  logic signed [32:0] xn, yn;
  logic               in_square;

  assign xn = 33'($signed({1'b0, d10.pos_x})) + 33'(px10 >>> 16);
  assign yn = 33'($signed({1'b0, d10.pos_y})) + 33'(py10 >>> 16);
  assign in_square = ~xn[32] & ~yn[32] & (xn <= 33'(POS_ONE)) & (yn <= 33'(POS_ONE));

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.batch_done <= d10.batch_end;
      if (d10.is_active && in_square) begin
        out_data.new_x        <= xn[POS_W-1:0];
        out_data.new_y        <= yn[POS_W-1:0];
        out_data.still_active <= 1'b1;
      end else begin
        out_data.new_x        <= d10.pos_x;
        out_data.new_y        <= d10.pos_y;
        out_data.still_active <= 1'b0;
      end
    end
  end

endmodule
